// ===== sv/bap_pkg.sv =====
// shared types and constants for the block average pixelate design
package bap_pkg;

    localparam int DEF_MAX_REGION_WIDTH  = 1024;
    localparam int DEF_MAX_REGION_HEIGHT = 1024;
    localparam int DEF_MAX_BLOCK         = 64;

    localparam int PIX_W    = 8;
    localparam int PIX_MAX  = 255;
    localparam int QUOT_W   = 8;
    localparam int COORD_W  = 10;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_DIM_W  = 11;
    localparam int CFG_BLK_W  = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE    = 2'd2;

    localparam logic [CFG_DIM_W-1:0] RST_REGION_WIDTH  = 11'd1;
    localparam logic [CFG_DIM_W-1:0] RST_REGION_HEIGHT = 11'd1;
    localparam logic [CFG_BLK_W-1:0] RST_BLOCK_SIZE    = 7'd14;

    typedef struct packed {
        logic take_pixel;
        logic accumulate;
        logic div_step;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic block_end;
        logic div_last;
        logic out_free;
    } t_ctrl_stat;

endpackage

// ===== sv/bap_ram.sv =====
// generic single write port ram with registered read
module bap_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/bap_ctrl.sv =====
// controller state machine for the block average pixelate design
module bap_ctrl
    import bap_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_ctrl_stat i_stat,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ACC  = 4'b0010,
        S_DIV  = 4'b0100,
        S_LOAD = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_state = i_stat.block_end ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (i_stat.div_last) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_cmd.take_pixel = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.accumulate = (r_state == S_ACC);
    assign o_cmd.div_step   = (r_state == S_DIV);
    assign o_cmd.load_out   = (r_state == S_LOAD) && i_stat.out_free;

endmodule

// ===== sv/bap_dp.sv =====
// datapath: settings, block position counters, sum memory, divider, output register
module bap_dp
    import bap_pkg::*;
#(
    parameter int MAX_REGION_WIDTH  = DEF_MAX_REGION_WIDTH,
    parameter int MAX_REGION_HEIGHT = DEF_MAX_REGION_HEIGHT,
    parameter int MAX_BLOCK         = DEF_MAX_BLOCK
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [IN_DATA_W-1:0]  i_pixel,
    input  t_ctrl_cmd             i_cmd,
    output t_ctrl_stat            o_stat,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready
);

    localparam int COL_W = (MAX_REGION_WIDTH > 1) ? $clog2(MAX_REGION_WIDTH) : 1;
    localparam int ROW_W = (MAX_REGION_HEIGHT > 1) ? $clog2(MAX_REGION_HEIGHT) : 1;
    localparam int BLK_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int BS_W  = $clog2(MAX_BLOCK + 1);
    localparam int CNT_W = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
    localparam int SUM_W = $clog2(MAX_BLOCK * MAX_BLOCK * PIX_MAX + 1);
    localparam int DIV_W = CNT_W + QUOT_W;
    localparam int STEP_W = $clog2(QUOT_W);
    localparam int PAD_W = OUT_DATA_W - 2 * COORD_W - 3 * QUOT_W;

    // settings
    logic [CFG_DIM_W-1:0] r_cfg_width;
    logic [CFG_DIM_W-1:0] r_cfg_height;
    logic [CFG_BLK_W-1:0] r_cfg_block;
    logic                 restart;

    logic [COL_W-1:0] w_m1;
    logic [ROW_W-1:0] h_m1;
    logic [BLK_W-1:0] bs_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RST_REGION_WIDTH;
            r_cfg_height <= RST_REGION_HEIGHT;
            r_cfg_block  <= RST_BLOCK_SIZE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_REGION_WIDTH:  r_cfg_width  <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_REGION_HEIGHT: r_cfg_height <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_BLOCK_SIZE:    r_cfg_block  <= i_cfg_data[CFG_BLK_W-1:0];
                default: ;
            endcase
        end
    end

    assign restart = i_cfg_we && (i_cfg_index == CFG_REGION_WIDTH ||
                                  i_cfg_index == CFG_REGION_HEIGHT ||
                                  i_cfg_index == CFG_BLOCK_SIZE);

    // clamped last positions
    always_comb begin
        if (r_cfg_width == '0) begin
            w_m1 = '0;
        end else if (32'(r_cfg_width) > MAX_REGION_WIDTH) begin
            w_m1 = COL_W'(MAX_REGION_WIDTH - 1);
        end else begin
            w_m1 = COL_W'(r_cfg_width - 1'b1);
        end
        if (r_cfg_height == '0) begin
            h_m1 = '0;
        end else if (32'(r_cfg_height) > MAX_REGION_HEIGHT) begin
            h_m1 = ROW_W'(MAX_REGION_HEIGHT - 1);
        end else begin
            h_m1 = ROW_W'(r_cfg_height - 1'b1);
        end
        if (r_cfg_block == '0) begin
            bs_m1 = '0;
        end else if (32'(r_cfg_block) > MAX_BLOCK) begin
            bs_m1 = BLK_W'(MAX_BLOCK - 1);
        end else begin
            bs_m1 = BLK_W'(r_cfg_block - 1'b1);
        end
    end

    // pixel latch
    logic [PIX_W-1:0] r_pix_r;
    logic [PIX_W-1:0] r_pix_g;
    logic [PIX_W-1:0] r_pix_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_pixel) begin
            r_pix_r <= i_pixel[PIX_W-1:0];
            r_pix_g <= i_pixel[2*PIX_W-1:PIX_W];
            r_pix_b <= i_pixel[3*PIX_W-1:2*PIX_W];
        end
    end

    // position counters
    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] r_bc;
    logic [BLK_W-1:0] r_cib;
    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] r_br;
    logic [BLK_W-1:0] r_rib;

    logic last_c;
    logic last_r;
    logic block_end;
    logic block_first;
    logic region_end;

    assign last_c      = (r_cib == bs_m1) || (r_col == w_m1);
    assign last_r      = (r_rib == bs_m1) || (r_row == h_m1);
    assign block_end   = last_c && last_r;
    assign block_first = (r_cib == '0) && (r_rib == '0);
    assign region_end  = (r_col == w_m1) && (r_row == h_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_col <= '0;
            r_bc  <= '0;
            r_cib <= '0;
            r_row <= '0;
            r_br  <= '0;
            r_rib <= '0;
        end else if (i_cmd.accumulate) begin
            if (r_col == w_m1) begin
                r_col <= '0;
                r_bc  <= '0;
                r_cib <= '0;
                if (r_row == h_m1) begin
                    r_row <= '0;
                    r_br  <= '0;
                    r_rib <= '0;
                end else begin
                    r_row <= r_row + 1'b1;
                    if (r_rib == bs_m1) begin
                        r_rib <= '0;
                        r_br  <= r_br + 1'b1;
                    end else begin
                        r_rib <= r_rib + 1'b1;
                    end
                end
            end else begin
                r_col <= r_col + 1'b1;
                if (r_cib == bs_m1) begin
                    r_cib <= '0;
                    r_bc  <= r_bc + 1'b1;
                end else begin
                    r_cib <= r_cib + 1'b1;
                end
            end
        end
    end

    // per block column sums, a block's first pixel starts a fresh sum
    logic [3*SUM_W-1:0] rd_data;
    logic [3*SUM_W-1:0] wr_data;
    logic [SUM_W-1:0]   sum_r;
    logic [SUM_W-1:0]   sum_g;
    logic [SUM_W-1:0]   sum_b;
    logic [3*SUM_W-1:0] base;

    assign base  = block_first ? '0 : rd_data;
    assign sum_r = base[SUM_W-1:0] + SUM_W'(r_pix_r);
    assign sum_g = base[2*SUM_W-1:SUM_W] + SUM_W'(r_pix_g);
    assign sum_b = base[3*SUM_W-1:2*SUM_W] + SUM_W'(r_pix_b);
    assign wr_data = block_end ? '0 : {sum_b, sum_g, sum_r};

    bap_ram #(
        .DATA_W (3 * SUM_W),
        .DEPTH  (MAX_REGION_WIDTH)
    ) u_sums (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.accumulate),
        .i_wr_addr (r_bc),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.take_pixel),
        .i_rd_addr (r_bc),
        .o_rd_data (rd_data)
    );

    // clipped pixel count
    logic [BS_W-1:0]  blk_w;
    logic [BS_W-1:0]  blk_h;
    logic [CNT_W-1:0] count;

    assign blk_w = BS_W'(r_cib) + BS_W'(1);
    assign blk_h = BS_W'(r_rib) + BS_W'(1);
    assign count = CNT_W'(blk_w) * CNT_W'(blk_h);

    // restoring divider, one quotient bit per cycle for all three channels
    logic [CNT_W-1:0]  r_n;
    logic [STEP_W-1:0] r_step;
    logic [SUM_W-1:0]  r_rem_r;
    logic [SUM_W-1:0]  r_rem_g;
    logic [SUM_W-1:0]  r_rem_b;
    logic [QUOT_W-1:0] r_q_r;
    logic [QUOT_W-1:0] r_q_g;
    logic [QUOT_W-1:0] r_q_b;
    logic [COORD_W-1:0] r_pend_bc;
    logic [COORD_W-1:0] r_pend_br;
    logic               r_pend_done;

    logic [DIV_W-1:0] trial;
    logic             ge_r;
    logic             ge_g;
    logic             ge_b;

    assign trial = DIV_W'(r_n) << r_step;
    assign ge_r  = DIV_W'(r_rem_r) >= trial;
    assign ge_g  = DIV_W'(r_rem_g) >= trial;
    assign ge_b  = DIV_W'(r_rem_b) >= trial;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accumulate && block_end) begin
            r_n         <= count;
            r_step      <= STEP_W'(QUOT_W - 1);
            r_rem_r     <= sum_r;
            r_rem_g     <= sum_g;
            r_rem_b     <= sum_b;
            r_pend_bc   <= COORD_W'(r_bc);
            r_pend_br   <= COORD_W'(r_br);
            r_pend_done <= region_end;
        end else if (i_cmd.div_step) begin
            r_step <= r_step - 1'b1;
            r_q_r  <= {r_q_r[QUOT_W-2:0], ge_r};
            r_q_g  <= {r_q_g[QUOT_W-2:0], ge_g};
            r_q_b  <= {r_q_b[QUOT_W-2:0], ge_b};
            if (ge_r) begin
                r_rem_r <= SUM_W'(DIV_W'(r_rem_r) - trial);
            end
            if (ge_g) begin
                r_rem_g <= SUM_W'(DIV_W'(r_rem_g) - trial);
            end
            if (ge_b) begin
                r_rem_b <= SUM_W'(DIV_W'(r_rem_b) - trial);
            end
        end
    end

    // output register
    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic                  r_m_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_m_data <= {{PAD_W{1'b0}}, r_q_b, r_q_g, r_q_r, r_pend_br, r_pend_bc};
            r_m_user <= r_pend_done;
        end
    end

    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;
    assign o_m_tvalid = r_m_valid;

    assign o_stat.block_end = block_end;
    assign o_stat.div_last  = (r_step == '0);
    assign o_stat.out_free  = !r_m_valid || i_m_tready;

endmodule

// ===== sv/block_average_pixelate.sv =====
// top level: block average pixelation over a raster region
// a pixel that closes no block first reads its block column's sum
// from the sum memory, then adds to it and writes it back
// a pixel that closes a block does the same, then runs the shared restoring divider
// (one quotient bit a cycle) and loads the output register once that is free
// reset: settings return to width 1, height 1, block 14, position to the origin;
// the sum memory is not cleared, a block's first pixel starts its sum afresh
module block_average_pixelate
    import bap_pkg::*;
#(
    parameter int MAX_REGION_WIDTH  = DEF_MAX_REGION_WIDTH,
    parameter int MAX_REGION_HEIGHT = DEF_MAX_REGION_HEIGHT,
    parameter int MAX_BLOCK         = DEF_MAX_BLOCK
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pixel_red, pixel_green, pixel_blue
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // block_column, block_row, mean_red, mean_green, mean_blue, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // region_done
    output logic                  m_axis_tuser
);

    t_ctrl_cmd  cmd;
    t_ctrl_stat stat;

    bap_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bap_dp #(
        .MAX_REGION_WIDTH  (MAX_REGION_WIDTH),
        .MAX_REGION_HEIGHT (MAX_REGION_HEIGHT),
        .MAX_BLOCK         (MAX_BLOCK)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pixel     (s_axis_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready)
    );

endmodule

// ===== tb/block_mean_checker.sv =====
// checker for block_average_pixelate: watches the channels, predicts block means, compares
`timescale 1ns / 100ps

module block_mean_checker
    import bap_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    // pixel_red, pixel_green, pixel_blue
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // block_column, block_row, mean_red, mean_green, mean_blue, zero pad
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    // region_done
    input  logic                  m_axis_tuser,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_means_checked,
    output int                    o_regions_closed
);

    localparam int ROW_LSB   = COORD_W;
    localparam int RED_LSB   = 2 * COORD_W;
    localparam int GREEN_LSB = RED_LSB + QUOT_W;
    localparam int BLUE_LSB  = GREEN_LSB + QUOT_W;

    typedef struct {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [QUOT_W-1:0]  red;
        logic [QUOT_W-1:0]  green;
        logic [QUOT_W-1:0]  blue;
        logic               done;
    } t_block_mean;

    t_block_mean expected_means[$];

    logic [CFG_DIM_W-1:0] width_reg;
    logic [CFG_DIM_W-1:0] height_reg;
    logic [CFG_BLK_W-1:0] block_reg;
    int col_pos;
    int row_pos;
    int red_sum[DEF_MAX_REGION_WIDTH];
    int green_sum[DEF_MAX_REGION_WIDTH];
    int blue_sum[DEF_MAX_REGION_WIDTH];

    int fail_count = 0;
    int pending_count = 0;
    int means_checked = 0;
    int regions_closed = 0;

    assign o_fail_count     = fail_count;
    assign o_pending        = pending_count;
    assign o_means_checked  = means_checked;
    assign o_regions_closed = regions_closed;

    function automatic int clamp_setting(input int value, input int hi);
        if (value == 0) return 1;
        if (value > hi) return hi;
        return value;
    endfunction

    task automatic restart_region();
        col_pos = 0;
        row_pos = 0;
        for (int i = 0; i < DEF_MAX_REGION_WIDTH; i++) begin
            red_sum[i]   = 0;
            green_sum[i] = 0;
            blue_sum[i]  = 0;
        end
    endtask

    task automatic apply_setting();
        case (i_cfg_index)
            CFG_REGION_WIDTH: begin
                width_reg = i_cfg_data[CFG_DIM_W-1:0];
                restart_region();
            end
            CFG_REGION_HEIGHT: begin
                height_reg = i_cfg_data[CFG_DIM_W-1:0];
                restart_region();
            end
            CFG_BLOCK_SIZE: begin
                block_reg = i_cfg_data[CFG_BLK_W-1:0];
                restart_region();
            end
            default: begin
            end
        endcase
    endtask

    task automatic predict_block_mean(input logic [IN_DATA_W-1:0] pix);
        int w, h, bs, c, r, bc, br, bw, bh, n;
        logic last_col, last_row;
        t_block_mean m;
        w  = clamp_setting(int'(width_reg), DEF_MAX_REGION_WIDTH);
        h  = clamp_setting(int'(height_reg), DEF_MAX_REGION_HEIGHT);
        bs = clamp_setting(int'(block_reg), DEF_MAX_BLOCK);
        c  = (col_pos >= w) ? 0 : col_pos;
        r  = (row_pos >= h) ? 0 : row_pos;
        bc = c / bs;
        br = r / bs;
        red_sum[bc]   += int'(pix[0 +: PIX_W]);
        green_sum[bc] += int'(pix[PIX_W +: PIX_W]);
        blue_sum[bc]  += int'(pix[2*PIX_W +: PIX_W]);
        last_col = (c % bs == bs - 1) || (c == w - 1);
        last_row = (r % bs == bs - 1) || (r == h - 1);
        if (last_col && last_row) begin
            bw = w - bc * bs;
            bh = h - br * bs;
            if (bw > bs) bw = bs;
            if (bh > bs) bh = bs;
            n = bw * bh;
            m.column = bc[COORD_W-1:0];
            m.row    = br[COORD_W-1:0];
            m.red    = QUOT_W'(red_sum[bc] / n);
            m.green  = QUOT_W'(green_sum[bc] / n);
            m.blue   = QUOT_W'(blue_sum[bc] / n);
            m.done   = (c == w - 1) && (r == h - 1);
            expected_means.push_back(m);
            red_sum[bc]   = 0;
            green_sum[bc] = 0;
            blue_sum[bc]  = 0;
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    task automatic compare_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    task automatic check_block_mean();
        t_block_mean m;
        if (expected_means.size() == 0) begin
            $error("block mean item with none expected: tdata %h tuser %b",
                   m_axis_tdata, m_axis_tuser);
            fail_count++;
        end else begin
            m = expected_means.pop_front();
            compare_field("block_column", int'(m.column),
                          int'(m_axis_tdata[0 +: COORD_W]));
            compare_field("block_row", int'(m.row),
                          int'(m_axis_tdata[ROW_LSB +: COORD_W]));
            compare_field("mean_red", int'(m.red),
                          int'(m_axis_tdata[RED_LSB +: QUOT_W]));
            compare_field("mean_green", int'(m.green),
                          int'(m_axis_tdata[GREEN_LSB +: QUOT_W]));
            compare_field("mean_blue", int'(m.blue),
                          int'(m_axis_tdata[BLUE_LSB +: QUOT_W]));
            compare_field("region_done", int'(m.done), int'(m_axis_tuser));
            means_checked++;
            if (m.done) regions_closed++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = RST_REGION_WIDTH;
            height_reg = RST_REGION_HEIGHT;
            block_reg  = RST_BLOCK_SIZE;
            restart_region();
            expected_means.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) check_block_mean();
            if (i_cfg_we) apply_setting();
            if (s_axis_tvalid && s_axis_tready) predict_block_mean(s_axis_tdata);
        end
        pending_count = expected_means.size();
    end

endmodule

// ===== tb/testbench.sv =====
// testbench top for block_average_pixelate: clock, reset, pixel stimulus and verdict
`timescale 1ns / 100ps

module testbench;
    import bap_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int TARGET_PIXELS = 1350;
    localparam int SETTLE_CYCLES = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    int fail_count;
    int pending;
    int means_checked;
    int regions_closed;

    int  cycle_count = 0;
    int  pixels_sent = 0;
    int  settings_written = 0;
    int  phases = 0;
    int  burst_left = 0;
    int  ready_hold = 0;
    bit  full_rate = 1'b0;

    block_average_pixelate u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    block_mean_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .m_axis_tuser     (m_axis_tuser),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_means_checked  (means_checked),
        .o_regions_closed (regions_closed)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver holds ready low or high for stretches of random length, or high throughout at full rate
    always @(negedge i_clk) begin
        if (full_rate) begin
            m_axis_tready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold--;
        end else begin
            ready_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 24)
                                                     : $urandom_range(0, 3);
            m_axis_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    function automatic logic [IN_DATA_W-1:0] pick_pixel(input int flavor);
        logic [2:0] bits;
        bits = 3'($urandom);
        case (flavor)
            0: return {IN_DATA_W{1'b1}};
            1: return {{PIX_W{bits[2]}}, {PIX_W{bits[1]}}, {PIX_W{bits[0]}}};
            default: return IN_DATA_W'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input logic [IN_DATA_W-1:0] pix);
        int gap;
        if (burst_left == 0 && !full_rate) begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : $urandom_range(0, 2);
            burst_left = $urandom_range(1, 20);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        if (burst_left > 0) burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        pixels_sent++;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input int value,
                                 input bit last);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        @(negedge i_clk);
        if (last) i_cfg_we <= 1'b0;
        settings_written++;
    endtask

    task automatic run_phase(input int w_data, input int h_data, input int bs_data,
                             input int n_pix, input int flavor);
        int split;
        settle();
        write_setting(CFG_REGION_WIDTH, w_data, 1'b0);
        write_setting(CFG_REGION_HEIGHT, h_data, 1'b0);
        write_setting(CFG_BLOCK_SIZE, bs_data, 1'b1);
        phases++;
        // a write to the unused index mid region must leave position and sums alone
        split = ($urandom_range(0, 7) == 0 && n_pix > 1) ? $urandom_range(1, n_pix - 1) : 0;
        for (int i = 0; i < n_pix; i++) begin
            if (split != 0 && i == split) begin
                settle();
                write_setting(CFG_UNUSED, $urandom, 1'b1);
            end
            send_pixel(pick_pixel(flavor));
        end
    endtask

    initial begin
        int w, h, bs, n;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings make every pixel a whole region, sent back to back
        full_rate = 1'b1;
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'hAA55AA);
        send_pixel(24'h55AA55);
        send_pixel(24'h0180FE);
        full_rate = 1'b0;

        // zero settings act as one
        run_phase(0, 0, 0, 2, 2);

        // unused index between two halves of one block
        run_phase(2, 2, 2, 2, 2);
        settle();
        write_setting(CFG_UNUSED, 11'h7FF, 1'b1);
        send_pixel(pick_pixel(2));
        send_pixel(pick_pixel(2));

        // oversized settings saturate
        run_phase(11'h7FF, 11'h7FF, 11'h7FF, 3, 2);

        // clipped edge blocks at full intensity
        run_phase(3, 3, 2, 9, 0);

        while (pixels_sent < TARGET_PIXELS) begin
            n = $urandom_range(0, 5);
            case ($urandom_range(0, 11))
                0: run_phase($urandom_range(0, 1) ? 1024 : $urandom_range(1025, 2047),
                             $urandom_range(0, 1), DEF_MAX_BLOCK,
                             $urandom_range(64, 320), n);
                1: run_phase($urandom_range(1, 2),
                             $urandom_range(0, 1) ? 1024 : $urandom_range(512, 2047),
                             $urandom_range(1, 4), $urandom_range(40, 150), n);
                2: begin
                    w = $urandom_range(1, 12);
                    h = $urandom_range(1, 12);
                    run_phase(w, h, $urandom_range(0, 2047), w * h * 2, n);
                end
                default: begin
                    w  = $urandom_range(1, 24);
                    h  = $urandom_range(1, 16);
                    bs = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 64)
                                                     : $urandom_range(1, 9);
                    if ($urandom_range(0, 3) == 0)
                        run_phase(w, h, bs, $urandom_range(1, w * h), n);
                    else if (w * h <= 150)
                        run_phase(w, h, bs, w * h * $urandom_range(1, 2), n);
                    else
                        run_phase(w, h, bs, w * h, n);
                end
            endcase
        end

        settle();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("covered %0d pixels over %0d region settings with %0d register writes",
                 pixels_sent, phases, settings_written);
        $display("checked %0d block means, %0d of them closing a region",
                 means_checked, regions_closed);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
